@@ rtl/core/pdts_pkg.sv @@
// shared constants for the priority delay task scheduler
// no dependencies
package pdts_pkg;

  localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_RERUN    = 2'd3;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_READY_FULL  = 2'd1;
  localparam logic [1:0] STATUS_DELAY_FULL  = 2'd2;
  localparam logic [1:0] STATUS_NO_CURRENT  = 2'd3;

  localparam int PRIO_BITS  = 8;
  localparam int DELAY_BITS = 16;

endpackage

@@ rtl/core/pdts_if.sv @@
// event and result channels of the priority delay task scheduler
// no dependencies
interface pdts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  task_id;
  logic [7:0]  priority_req;
  logic [15:0] delay_ticks;
  modport source (output valid, mode, task_id, priority_req, delay_ticks, input ready);
  modport sink (input valid, mode, task_id, priority_req, delay_ticks, output ready);
endinterface

interface pdts_rsp_if;
  logic       valid;
  logic       ready;
  logic       dispatched_valid;
  logic [7:0] dispatched_task;
  logic [7:0] dispatched_priority;
  logic [4:0] ready_count;
  logic [4:0] delayed_count;
  logic [1:0] status;
  modport source (output valid, dispatched_valid, dispatched_task, dispatched_priority,
                  ready_count, delayed_count, status, input ready);
  modport sink (input valid, dispatched_valid, dispatched_task, dispatched_priority,
                ready_count, delayed_count, status, output ready);
endinterface

@@ rtl/core/priority_delay_task_scheduler.sv @@
// top level of the priority delay task scheduler
// depends on pdts_pkg, pdts_if and pdts_ram
//
// One event is taken at a time and yields one result beat. Both queues live in
// ring buffers in memory. A sorted insert walks back from the tail, reading
// each entry it moves in S_RINS and writing it one slot up in S_RINS_CHK. Each
// expired task found by a tick is put into the ready queue by such an insert.
// A new event is taken while a result beat waits on rsp; only the next beat
// stalls in S_DONE until that one is taken. Delays are kept as deadlines
// against a free-running tick counter, so a tick touches only expired entries.
module priority_delay_task_scheduler #(
  parameter int READY_DEPTH  = 16,
  parameter int DELAY_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input logic clk,
  input logic rst,
  pdts_req_if.sink   req,
  pdts_rsp_if.source rsp
);
  localparam int PB  = pdts_pkg::PRIO_BITS;
  localparam int DB  = pdts_pkg::DELAY_BITS;
  localparam int RAW = $clog2(READY_DEPTH);
  localparam int DAW = $clog2(DELAY_DEPTH);
  localparam int RJW = $clog2(READY_DEPTH + 1);
  localparam int DJW = $clog2(DELAY_DEPTH + 1);
  localparam int RW  = TASK_ID_BITS + PB;
  localparam int DW  = TASK_ID_BITS + PB + DB;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RINS, S_RINS_CHK, S_DINS, S_DINS_CHK,
    S_DISP_WAIT, S_TICK_RD, S_TICK_CHK, S_DONE
  } state_t;

  state_t state;
  logic [RAW-1:0] rhead;
  logic [RJW-1:0] rfill, rj;
  logic [DAW-1:0] dhead;
  logic [DJW-1:0] dfill, dj;
  logic [DB-1:0]  now;
  logic [TASK_ID_BITS-1:0] cur_id, ins_id, req_id, dt;
  logic [PB-1:0]  cur_prio, ins_prio, req_prio, dp;
  logic           cur_valid, ins_tick, dv;
  logic [1:0]     req_mode, status;
  logic [DB-1:0]  req_delay;
  logic           out_valid;

  logic           r_we, d_we;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [RW-1:0]  r_wdata, r_rdata;
  logic [DW-1:0]  d_wdata, d_rdata;

  logic [31:0] id_w, rfill_w, dfill_w, dt_w;
  logic [PB-1:0] rd_prio;
  logic [DB-1:0] rd_remain;

  function automatic logic [RAW-1:0] rwrap(input logic [RAW-1:0] b, input logic [RJW-1:0] o);
    logic [RJW:0] s;
    s = (RJW+1)'(b) + (RJW+1)'(o);
    if (s >= (RJW+1)'(READY_DEPTH)) s = s - (RJW+1)'(READY_DEPTH);
    return s[RAW-1:0];
  endfunction

  function automatic logic [DAW-1:0] dwrap(input logic [DAW-1:0] b, input logic [DJW-1:0] o);
    logic [DJW:0] s;
    s = (DJW+1)'(b) + (DJW+1)'(o);
    if (s >= (DJW+1)'(DELAY_DEPTH)) s = s - (DJW+1)'(DELAY_DEPTH);
    return s[DAW-1:0];
  endfunction

  pdts_ram #(.WIDTH(RW), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata)
  );
  pdts_ram #(.WIDTH(DW), .DEPTH(DELAY_DEPTH)) u_delay_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  assign id_w      = 32'(req.task_id);
  assign rfill_w   = 32'(rfill);
  assign dfill_w   = 32'(dfill);
  assign dt_w      = 32'(dt);
  assign rd_prio   = r_rdata[PB-1:0];
  assign rd_remain = d_rdata[DB-1:0] - now;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;

  always_comb begin
    r_we    = 1'b0;
    r_waddr = rwrap(rhead, rj);
    r_wdata = {ins_id, ins_prio};
    r_raddr = rhead;
    d_we    = 1'b0;
    d_waddr = dwrap(dhead, dj);
    d_wdata = {cur_id, cur_prio, DB'(now + req_delay)};
    d_raddr = dhead;
    case (state)
      S_RINS: begin
        if (rfill != RJW'(READY_DEPTH)) begin
          if (rj == '0) begin
            r_we = 1'b1;
          end else begin
            r_raddr = rwrap(rhead, rj - RJW'(1));
          end
        end
      end
      S_RINS_CHK: begin
        r_we = 1'b1;
        if (rd_prio > ins_prio) begin
          r_wdata = r_rdata;
        end
      end
      S_DINS: begin
        if (dfill != DJW'(DELAY_DEPTH)) begin
          if (dj == '0) begin
            d_we = 1'b1;
          end else begin
            d_raddr = dwrap(dhead, dj - DJW'(1));
          end
        end
      end
      S_DINS_CHK: begin
        d_we = 1'b1;
        if (rd_remain > req_delay) begin
          d_wdata = d_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rhead     <= '0;
      rfill     <= '0;
      dhead     <= '0;
      dfill     <= '0;
      now       <= '0;
      cur_id    <= '0;
      cur_prio  <= '0;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_mode  <= req.mode;
            req_id    <= id_w[TASK_ID_BITS-1:0];
            req_prio  <= req.priority_req;
            req_delay <= req.delay_ticks;
            status    <= pdts_pkg::STATUS_OK;
            dv        <= 1'b0;
            dt        <= '0;
            dp        <= '0;
            state     <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (req_mode)
            pdts_pkg::MODE_ENQUEUE: begin
              ins_id   <= req_id;
              ins_prio <= req_prio;
              ins_tick <= 1'b0;
              rj       <= rfill;
              state    <= S_RINS;
            end
            pdts_pkg::MODE_DISPATCH: begin
              state <= (rfill == '0) ? S_DONE : S_DISP_WAIT;
            end
            pdts_pkg::MODE_TICK: begin
              now   <= now + DB'(1);
              state <= S_TICK_RD;
            end
            default: begin
              if (!cur_valid) begin
                status <= pdts_pkg::STATUS_NO_CURRENT;
                state  <= S_DONE;
              end else if (req_delay == '0) begin
                ins_id   <= cur_id;
                ins_prio <= cur_prio;
                ins_tick <= 1'b0;
                rj       <= rfill;
                state    <= S_RINS;
              end else begin
                dj    <= dfill;
                state <= S_DINS;
              end
            end
          endcase
        end
        S_RINS: begin
          if (rfill == RJW'(READY_DEPTH)) begin
            status <= pdts_pkg::STATUS_READY_FULL;
            state  <= ins_tick ? S_TICK_RD : S_DONE;
          end else if (rj == '0) begin
            rfill <= rfill + RJW'(1);
            state <= ins_tick ? S_TICK_RD : S_DONE;
          end else begin
            state <= S_RINS_CHK;
          end
        end
        S_RINS_CHK: begin
          if (rd_prio > ins_prio) begin
            rj    <= rj - RJW'(1);
            state <= S_RINS;
          end else begin
            rfill <= rfill + RJW'(1);
            state <= ins_tick ? S_TICK_RD : S_DONE;
          end
        end
        S_DINS: begin
          if (dfill == DJW'(DELAY_DEPTH)) begin
            status <= pdts_pkg::STATUS_DELAY_FULL;
            state  <= S_DONE;
          end else if (dj == '0) begin
            dfill <= dfill + DJW'(1);
            state <= S_DONE;
          end else begin
            state <= S_DINS_CHK;
          end
        end
        S_DINS_CHK: begin
          if (rd_remain > req_delay) begin
            dj    <= dj - DJW'(1);
            state <= S_DINS;
          end else begin
            dfill <= dfill + DJW'(1);
            state <= S_DONE;
          end
        end
        S_DISP_WAIT: begin
          cur_id    <= r_rdata[RW-1:PB];
          cur_prio  <= rd_prio;
          cur_valid <= 1'b1;
          dv        <= 1'b1;
          dt        <= r_rdata[RW-1:PB];
          dp        <= rd_prio;
          rhead     <= rwrap(rhead, RJW'(1));
          rfill     <= rfill - RJW'(1);
          state     <= S_DONE;
        end
        S_TICK_RD: begin
          state <= (dfill == '0) ? S_DONE : S_TICK_CHK;
        end
        S_TICK_CHK: begin
          if (rd_remain == '0) begin
            dhead    <= dwrap(dhead, DJW'(1));
            dfill    <= dfill - DJW'(1);
            ins_id   <= d_rdata[DW-1:PB+DB];
            ins_prio <= d_rdata[PB+DB-1:DB];
            ins_tick <= 1'b1;
            rj       <= rfill;
            state    <= S_RINS;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid               <= 1'b1;
            rsp.dispatched_valid    <= dv;
            rsp.dispatched_task     <= dt_w[7:0];
            rsp.dispatched_priority <= dp;
            rsp.ready_count         <= rfill_w[4:0];
            rsp.delayed_count       <= dfill_w[4:0];
            rsp.status              <= status;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ rtl/core/pdts_ram.sv @@
// generic ram, one write port, one read port with registered read data
// no dependencies
module pdts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
